>>> rtl/mtnc_pkg.sv
// ----------------------------------------------------------------------------
// mtnc_pkg
// Types, codes and byte classifiers shared by the markup nesting tracker.
// ----------------------------------------------------------------------------
package mtnc_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
    logic [7:0] bit_context;
  } in_item_t;

  typedef struct packed {
    logic [23:0] phase_context;
    logic [19:0] shape_context;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_TEMPLATE = 2'd1,
    KIND_TABLE    = 2'd2,
    KIND_LINK     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] line_column;
    logic [2:0] signature;
    logic       pipe_seen;
    logic       eq_seen;
  } frame_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_APPLY    = 3'd1,
    ST_OP       = 3'd2,
    ST_SCAN_RD  = 3'd3,
    ST_SCAN_CMP = 3'd4,
    ST_FIND_RD  = 3'd5,
    ST_FIND_CMP = 3'd6,
    ST_OUT      = 3'd7
  } state_t;

  // key inputs gathered from the tracker state
  typedef struct packed {
    logic       active;
    logic       compact;
    logic [2:0] tdep;
    logic [2:0] nest;
    logic       nb;
    logic [4:0] line_column;
    logic [2:0] signature;
    logic       pipe_seen;
    logic       eq_seen;
    logic [2:0] pre_cls;
    logic [7:0] bit_context;
  } key_ctx_t;

  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_MASK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMPACT     = 1'b1;

  localparam logic [4:0] COL_MAX   = 5'd31;
  localparam logic [5:0] TDEPTH_MAX = 6'd63;
  localparam logic [4:0] COL_MID   = 5'd12;

  localparam logic [2:0] SIG_PIPE     = 3'd1;
  localparam logic [2:0] SIG_EQUALS   = 3'd2;
  localparam logic [2:0] SIG_CLOSE_CB = 3'd3;
  localparam logic [2:0] SIG_NEWLINE  = 3'd4;
  localparam logic [2:0] SIG_OPEN_CB  = 3'd5;
  localparam logic [2:0] SIG_OPEN_SQ  = 3'd6;
  localparam logic [2:0] SIG_CLOSE_SQ = 3'd7;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  function automatic logic is_open_curly(input logic [7:0] c);
    return (c == 8'h7B) || (c == 8'h50);
  endfunction

  function automatic logic is_close_curly(input logic [7:0] c);
    return (c == 8'h7D) || (c == 8'h52);
  endfunction

  function automatic logic is_pipe(input logic [7:0] c);
    return (c == 8'h7C) || (c == 8'h51);
  endfunction

  function automatic logic is_equals(input logic [7:0] c);
    return (c == 8'h3D) || (c == 8'h4D);
  endfunction

  function automatic logic is_open_square(input logic [7:0] c);
    return c == 8'h5B;
  endfunction

  function automatic logic is_close_square(input logic [7:0] c);
    return c == 8'h5D;
  endfunction

  function automatic logic is_target(input logic [7:0] c, input logic [3:0] mask);
    return (mask[0] && is_pipe(c)) || (mask[1] && is_equals(c)) ||
           (mask[2] && is_close_curly(c)) || (mask[3] && (c == CH_NEWLINE));
  endfunction

  function automatic logic [1:0] col_band(input logic [4:0] col);
    logic [1:0] b;
    if (col == 5'd0) b = 2'd0;
    else if (col <= 5'd2) b = 2'd1;
    else if (col <= COL_MID) b = 2'd2;
    else b = 2'd3;
    return b;
  endfunction

  function automatic logic [2:0] byte_class(input logic [7:0] c);
    logic [2:0] k;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == CH_NEWLINE) k = 3'd1;
    else if (c >= 8'h30 && c <= 8'h39) k = 3'd2;
    else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) k = 3'd3;
    else if (is_pipe(c) || is_equals(c) || is_close_curly(c)) k = 3'd4;
    else k = 3'd5;
    return k;
  endfunction

endpackage

>>> rtl/mtnc_frame_ram.sv
// ----------------------------------------------------------------------------
// mtnc_frame_ram
// Frame stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mtnc_frame_ram
  import mtnc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  frame_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output frame_t           rd_data
);

  frame_t mem [DEPTH];
  frame_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mtnc_key.sv
// ----------------------------------------------------------------------------
// mtnc_key
// Builds the phase and shape context keys from the tracker state.
// ----------------------------------------------------------------------------
module mtnc_key
  import mtnc_pkg::*;
(
  input  key_ctx_t  ctx,
  output out_item_t keys
);

  logic [1:0]  lb;
  logic [11:0] skey;
  logic [15:0] fkey;
  logic [7:0]  ckey;
  logic [1:0]  ph;

  always_comb begin
    lb   = col_band(ctx.line_column);
    skey = ((({9'd0, ctx.tdep} * 12'd8 + {9'd0, ctx.nest}) * 12'd4 + {10'd0, lb})
            * 12'd9) + {9'd0, ctx.signature};
    fkey = (({3'd0, skey, ctx.pipe_seen} * 16'd2 + {15'd0, ctx.eq_seen}) * 16'd6)
           + {13'd0, ctx.pre_cls};
    ph   = ctx.pipe_seen ? (ctx.eq_seen ? 2'd2 : 2'd1) : 2'd0;
    ckey = (({7'd0, ctx.nb} * 8'd3 + {6'd0, ph}) * 8'd4 + {6'd0, lb}) * 8'd6
           + {5'd0, ctx.pre_cls};

    keys = '0;
    if (ctx.active) begin
      if (ctx.compact) begin
        keys.phase_context = {8'd0, ckey, 8'd0} + {16'd0, ctx.bit_context};
      end else begin
        keys.phase_context = {fkey, 8'd0} + {16'd0, ctx.bit_context};
        keys.shape_context = {skey, 8'd0} + {12'd0, ctx.bit_context};
      end
    end
  end

endmodule

>>> rtl/markup_template_nesting_context.sv
// ----------------------------------------------------------------------------
// markup_template_nesting_context
// Template/table/link nesting tracker producing two context keys per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per bit step (mode 0) or completed byte (mode 1).
//   out_* : one transaction per input, phase and shape context keys.
//   cfg_* : register writes, only while the block is idle.
// Steps from input accept to the output register:
//   bit step                 : ST_OUT
//   byte, no stack change    : ST_APPLY, ST_OP, ST_OUT (also push)
//   byte that pops           : as above, plus a read and a compare per frame
//                              scanned for the match and per frame scanned
//                              for the next template, before ST_OUT.
// One item at a time, taken the cycle after the result is loaded. The pop
// scan walks the frame memory's single read port one frame at a time, with
// a read state and a compare state per frame.
// Reset (synchronous, rst_n low) empties the stack, clears the history and
// sets the target mask to all ones. A stalled output holds its result; the
// block then waits with in_stall high until the output register frees.
// ----------------------------------------------------------------------------
module markup_template_nesting_context
  import mtnc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SUB_W = (CNT_W > 6) ? CNT_W : 6;

  state_t           st_r, st_nxt;
  in_item_t         item_r, item_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [1:0]       bsat_r, bsat_nxt;
  logic             target_r, target_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [5:0]       tdepth_r, tdepth_nxt;
  logic             top_valid_r, top_valid_nxt;
  logic [IDX_W-1:0] top_idx_r, top_idx_nxt;
  frame_t           cache_r, cache_nxt;
  op_t              op_r, op_nxt;
  kind_t            op_kind_r, op_kind_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] tcnt_r, tcnt_nxt;
  logic             first_r, first_nxt;
  logic             top_tmpl_r, top_tmpl_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [3:0]       mask_r;
  logic             compact_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  frame_t           wr_data;
  logic             rd_en;
  frame_t           rd_data;

  key_ctx_t         ctx;
  out_item_t        keys;

  logic [7:0]       c;
  frame_t           upd;
  frame_t           fresh;
  logic [CNT_W-1:0] match;
  logic             top_is_tmpl;
  logic [SUB_W-1:0] sub_a, sub_b;
  logic [6:0]       cnt_ext;

  mtnc_frame_ram #(
    .DEPTH (STACK_DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  mtnc_key u_key (
    .ctx  (ctx),
    .keys (keys)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      prev_r      <= '0;
      bsat_r      <= '0;
      target_r    <= 1'b0;
      count_r     <= '0;
      tdepth_r    <= '0;
      top_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= 4'hF;
      compact_r   <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      prev_r      <= prev_nxt;
      bsat_r      <= bsat_nxt;
      target_r    <= target_nxt;
      count_r     <= count_nxt;
      tdepth_r    <= tdepth_nxt;
      top_valid_r <= top_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TARGET_MASK: mask_r <= cfg_wdata;
          CFG_COMPACT:     compact_r <= cfg_wdata[0];
          default:         mask_r <= mask_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    top_idx_r  <= top_idx_nxt;
    cache_r    <= cache_nxt;
    op_r       <= op_nxt;
    op_kind_r  <= op_kind_nxt;
    ptr_r      <= ptr_nxt;
    tcnt_r     <= tcnt_nxt;
    first_r    <= first_nxt;
    top_tmpl_r <= top_tmpl_nxt;
    out_data_r <= out_data_nxt;
  end

  // key context from current state
  always_comb begin
    cnt_ext         = 7'(count_r);
    ctx.active      = top_valid_r && (tdepth_r != 6'd0) && target_r;
    ctx.compact     = compact_r;
    ctx.tdep        = (tdepth_r > 6'd7) ? 3'd7 : tdepth_r[2:0];
    ctx.nest        = (cnt_ext > 7'd8) ? 3'd7 : 3'(cnt_ext - 7'd1);
    ctx.nb          = tdepth_r > 6'd1;
    ctx.line_column = cache_r.line_column;
    ctx.signature   = cache_r.signature;
    ctx.pipe_seen   = cache_r.pipe_seen;
    ctx.eq_seen     = cache_r.eq_seen;
    ctx.pre_cls     = (bsat_r <= 2'd1) ? 3'd0 : byte_class(prev_r);
    ctx.bit_context = item_r.bit_context;
  end

  always_comb begin
    st_nxt        = st_r;
    item_nxt      = item_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    bsat_nxt      = bsat_r;
    target_nxt    = target_r;
    count_nxt     = count_r;
    tdepth_nxt    = tdepth_r;
    top_valid_nxt = top_valid_r;
    top_idx_nxt   = top_idx_r;
    cache_nxt     = cache_r;
    op_nxt        = op_r;
    op_kind_nxt   = op_kind_r;
    ptr_nxt       = ptr_r;
    tcnt_nxt      = tcnt_r;
    first_nxt     = first_r;
    top_tmpl_nxt  = top_tmpl_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = top_idx_r;
    wr_data       = cache_r;
    rd_en         = 1'b0;
    match         = count_r;
    top_is_tmpl   = top_tmpl_r;
    sub_a         = '0;
    sub_b         = '0;

    c = item_r.byte_value;

    // top template frame after this byte
    upd = cache_r;
    if (c == CH_NEWLINE) begin
      upd.line_column = '0;
      upd.signature   = SIG_NEWLINE;
      upd.pipe_seen   = 1'b0;
      upd.eq_seen     = 1'b0;
    end else begin
      if (cache_r.line_column < COL_MAX) upd.line_column = cache_r.line_column + 5'd1;
      if (is_pipe(c)) begin
        upd.signature = SIG_PIPE;
        upd.pipe_seen = 1'b1;
        upd.eq_seen   = 1'b0;
      end else if (is_equals(c)) begin
        upd.signature = SIG_EQUALS;
        if (cache_r.pipe_seen) upd.eq_seen = 1'b1;
      end else if (is_close_curly(c)) begin
        upd.signature = SIG_CLOSE_CB;
      end else if (is_open_curly(c)) begin
        upd.signature = SIG_OPEN_CB;
      end else if (is_open_square(c)) begin
        upd.signature = SIG_OPEN_SQ;
      end else if (is_close_square(c)) begin
        upd.signature = SIG_CLOSE_SQ;
      end
    end

    fresh      = '0;
    fresh.kind = op_kind_r;

    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          st_nxt   = in_data.mode ? ST_APPLY : ST_OUT;
        end
      end
      ST_APPLY: begin
        prev_nxt   = last_r;
        last_nxt   = c;
        target_nxt = is_target(c, mask_r);
        if (bsat_r != 2'd3) bsat_nxt = bsat_r + 2'd1;
        if (top_valid_r) begin
          cache_nxt = upd;
          wr_en     = 1'b1;
          wr_addr   = top_idx_r;
          wr_data   = upd;
        end
        op_nxt      = OP_NONE;
        op_kind_nxt = KIND_NONE;
        if (bsat_r != 2'd0) begin
          if (is_open_curly(last_r) && is_open_curly(c)) begin
            op_nxt = OP_PUSH; op_kind_nxt = KIND_TEMPLATE;
          end else if (is_open_curly(last_r) && is_pipe(c)) begin
            op_nxt = OP_PUSH; op_kind_nxt = KIND_TABLE;
          end else if (is_open_square(last_r) && is_open_square(c)) begin
            op_nxt = OP_PUSH; op_kind_nxt = KIND_LINK;
          end else if (is_close_curly(last_r) && is_close_curly(c)) begin
            op_nxt = OP_POP; op_kind_nxt = KIND_TEMPLATE;
          end else if (is_pipe(last_r) && is_close_curly(c)) begin
            op_nxt = OP_POP; op_kind_nxt = KIND_TABLE;
          end else if (is_close_square(last_r) && is_close_square(c)) begin
            op_nxt = OP_POP; op_kind_nxt = KIND_LINK;
          end
        end
        st_nxt = ST_OP;
      end
      ST_OP: begin
        st_nxt = ST_OUT;
        case (op_r)
          OP_PUSH: begin
            if (count_r < CNT_W'(STACK_DEPTH)) begin
              wr_en     = 1'b1;
              wr_addr   = IDX_W'(count_r);
              wr_data   = fresh;
              count_nxt = count_r + CNT_W'(1);
              if (op_kind_r == KIND_TEMPLATE) begin
                if (tdepth_r < TDEPTH_MAX) tdepth_nxt = tdepth_r + 6'd1;
                top_idx_nxt   = IDX_W'(count_r);
                top_valid_nxt = 1'b1;
                cache_nxt     = fresh;
              end
            end
          end
          OP_POP: begin
            if (count_r != '0) begin
              ptr_nxt   = IDX_W'(count_r - CNT_W'(1));
              tcnt_nxt  = '0;
              first_nxt = 1'b1;
              st_nxt    = ST_SCAN_RD;
            end
          end
          default: st_nxt = ST_OUT;
        endcase
      end
      ST_SCAN_RD: begin
        rd_en  = 1'b1;
        st_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        tcnt_nxt     = tcnt_r + CNT_W'(rd_data.kind == KIND_TEMPLATE);
        top_is_tmpl  = first_r ? (rd_data.kind == KIND_TEMPLATE) : top_tmpl_r;
        top_tmpl_nxt = top_is_tmpl;
        first_nxt    = 1'b0;
        if (rd_data.kind == op_kind_r || ptr_r == '0) begin
          if (rd_data.kind == op_kind_r) begin
            match = CNT_W'(ptr_r);
            sub_a = SUB_W'(tdepth_r);
            sub_b = SUB_W'(tcnt_nxt);
            tdepth_nxt = (sub_b >= sub_a) ? 6'd0 : 6'(sub_a - sub_b);
          end else begin
            match = count_r - CNT_W'(1);
            if (top_is_tmpl && tdepth_r != 6'd0) tdepth_nxt = tdepth_r - 6'd1;
          end
          count_nxt = match;
          st_nxt    = ST_OUT;
          if (top_valid_r && (CNT_W'(top_idx_r) >= match)) begin
            top_valid_nxt = 1'b0;
            if (match != '0) begin
              ptr_nxt = IDX_W'(match - CNT_W'(1));
              st_nxt  = ST_FIND_RD;
            end
          end
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
          st_nxt  = ST_SCAN_RD;
        end
      end
      ST_FIND_RD: begin
        rd_en  = 1'b1;
        st_nxt = ST_FIND_CMP;
      end
      ST_FIND_CMP: begin
        if (rd_data.kind == KIND_TEMPLATE) begin
          top_idx_nxt   = ptr_r;
          top_valid_nxt = 1'b1;
          cache_nxt     = rd_data;
          st_nxt        = ST_OUT;
        end else if (ptr_r == '0) begin
          st_nxt = ST_OUT;
        end else begin
          ptr_nxt = ptr_r - IDX_W'(1);
          st_nxt  = ST_FIND_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = keys;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/mtnc_checker.sv
// ----------------------------------------------------------------------------
// mtnc_checker
// Port-level checks for the markup nesting tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mtnc_checker
  import mtnc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // one transaction in flight: input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase_context == 24'd0) |-> out_data.shape_context == 20'd0)
    else $error("shape key without phase key");

  a_bc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.shape_context != 20'd0) |->
      out_data.shape_context[7:0] == out_data.phase_context[7:0])
    else $error("key bit contexts differ");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind markup_template_nesting_context mtnc_checker u_mtnc_checker (.*);
